[rtl/core/spmpwm_pkg.sv]
// Shared constants and types for the shared-period multichannel PWM unit.
package spmpwm_pkg;

	localparam int NUM_CHANNELS  = 4;
	localparam int COUNTER_WIDTH = 32;
	localparam int MAX_OUTPUTS   = 4;
	localparam int CC_CHANNELS   = 4;
	localparam int OUT_IDX_W     = $clog2(MAX_OUTPUTS);
	localparam int CH_IDX_W      = $clog2(NUM_CHANNELS);
	localparam int MAP_W         = 3;
	localparam int CFG_DATA_W    = 16;
	localparam int CFG_INDEX_W   = 3;

	localparam logic [31:0] NARROW_LIMIT = 32'd65536;
	localparam logic [COUNTER_WIDTH-1:0] NARROW_MASK = COUNTER_WIDTH'(17'h0FFFF);
	localparam logic [MAX_OUTPUTS-1:0]   LEVELS_RESET = {MAX_OUTPUTS{1'b1}};

	typedef enum logic [1:0] {
		STATUS_OK          = 2'd0,
		STATUS_BAD_CHANNEL = 2'd1,
		STATUS_UNSUPPORTED = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		MODE_UP     = 2'd0,
		MODE_DOWN   = 2'd1,
		MODE_CENTER = 2'd2
	} counter_mode_t;

	typedef enum logic {
		OP_TICK = 1'b0,
		OP_SET  = 1'b1
	} op_t;

	localparam logic [CFG_INDEX_W-1:0] REG_COUNTER_MODE     = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_PRESCALE_DIVISOR = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_WIDE_COUNTER     = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_COUNT     = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_MAP      = 3'd4;

endpackage

[rtl/core/shared_period_multichannel_pwm_unit.sv]
// Shared-period multichannel PWM unit: input register, single-pass update, result register.
//
//  channel   direction  handshake              payload
//  in        sink       in_valid / in_ready    op, channel, period, pulse
//  out       source     out_valid / out_ready  status, pin_levels, update_event
//  cfg       sink       cfg_we (no wait)       cfg_index, cfg_wdata
//
// The result register is loaded from the input register; one item per cycle sustained while out_ready is high.
// Each item is registered, then one pass of counter/compare logic updates the timer
// state and the result register in the same cycle.
// A result held by out_ready low stalls the input register; in_ready drops only then.
// arst_n resets configuration to defaults and clears timer state; levels start high, no channel armed.
module shared_period_multichannel_pwm_unit (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [spmpwm_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [spmpwm_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic                                   op,
	input  logic [2:0]                             channel,
	input  logic [31:0]                            period,
	input  logic [31:0]                            pulse,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [1:0]                             status,
	output logic [spmpwm_pkg::MAX_OUTPUTS-1:0]     pin_levels,
	output logic                                   update_event
);

	localparam int CW = spmpwm_pkg::COUNTER_WIDTH;
	localparam int NO = spmpwm_pkg::MAX_OUTPUTS;
	localparam int NC = spmpwm_pkg::NUM_CHANNELS;
	localparam int CH_IDX_W_L = spmpwm_pkg::CH_IDX_W;

	// configuration
	logic [1:0]  counter_mode_q;
	logic [15:0] prescale_divisor_q;
	logic        wide_counter_q;
	logic [2:0]  output_count_q;
	logic [spmpwm_pkg::MAP_W*NO-1:0] channel_map_q;

	// input stage
	logic        valid_s1;
	logic        op_s1;
	logic [2:0]  channel_s1;
	logic [31:0] period_s1;
	logic [31:0] pulse_s1;

	// timer state
	logic [CW-1:0] count_q, count_d;
	logic          down_q, down_d;
	logic [15:0]   prescale_q, prescale_d;
	logic [CW-1:0] reload_q, reload_d;
	logic [CW-1:0] compare_q [NC];
	logic [CW-1:0] compare_d [NC];
	logic [NO-1:0] active_q, active_d;
	logic [NC-1:0] cmp_en_q, cmp_en_d;
	logic [NC-1:0] armed_q, armed_d;
	logic          upd_en_q, upd_en_d;
	logic [NO-1:0] levels_q, levels_d;

	// result stage
	logic                   out_valid_q;
	spmpwm_pkg::status_t    status_q, status_d;
	logic [NO-1:0]          pin_levels_q;
	logic                   update_event_q, ev_d;

	logic          advance;
	logic [2:0]    n_out;
	logic [NO-1:0] used;
	logic [2:0]    map_ch [NO];

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	assign n_out = (output_count_q > 3'(NO)) ? 3'(NO) : output_count_q;

	always_comb begin
		for (int i = 0; i < NO; i++) begin
			used[i]   = 3'(i) < n_out;
			map_ch[i] = channel_map_q[spmpwm_pkg::MAP_W*i +: spmpwm_pkg::MAP_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_mode_q     <= spmpwm_pkg::MODE_UP;
			prescale_divisor_q <= '0;
			wide_counter_q     <= 1'b1;
			output_count_q     <= 3'd4;
			channel_map_q      <= 12'd2760;
		end else if (cfg_we) begin
			unique case (cfg_index)
				spmpwm_pkg::REG_COUNTER_MODE:     counter_mode_q     <= cfg_wdata[1:0];
				spmpwm_pkg::REG_PRESCALE_DIVISOR: prescale_divisor_q <= cfg_wdata;
				spmpwm_pkg::REG_WIDE_COUNTER:     wide_counter_q     <= cfg_wdata[0];
				spmpwm_pkg::REG_OUTPUT_COUNT:     output_count_q     <= cfg_wdata[2:0];
				spmpwm_pkg::REG_CHANNEL_MAP:      channel_map_q      <= cfg_wdata[11:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1      <= op;
			channel_s1 <= channel;
			period_s1  <= period;
			pulse_s1   <= pulse;
		end
	end

	always_comb begin
		logic [CW-1:0]         mask;
		logic [31:0]           per_adj;
		logic [31:0]           pul_adj;
		logic [CW:0]           count_inc;
		logic [NC-1:0]         ch_match;
		logic [CH_IDX_W_L-1:0] ch_idx;
		logic [spmpwm_pkg::OUT_IDX_W-1:0] idx;
		logic                  found;
		logic                  ch_ok;
		logic                  forced;
		logic                  upd;

		count_d   = count_q;
		down_d    = down_q;
		prescale_d = prescale_q;
		reload_d  = reload_q;
		compare_d = compare_q;
		active_d  = active_q;
		cmp_en_d  = cmp_en_q;
		armed_d   = armed_q;
		upd_en_d  = upd_en_q;
		levels_d  = levels_q;
		status_d  = spmpwm_pkg::STATUS_OK;
		ev_d      = 1'b0;

		mask      = wide_counter_q ? {CW{1'b1}} : spmpwm_pkg::NARROW_MASK;
		per_adj   = period_s1;
		pul_adj   = pulse_s1;
		count_inc = {1'b0, count_q} + (CW+1)'(1);
		ch_match  = '0;
		ch_idx    = CH_IDX_W_L'(channel_s1 - 3'd1);
		idx       = '0;
		found     = 1'b0;
		forced    = 1'b0;
		upd       = 1'b0;
		ch_ok     = (channel_s1 >= 3'd1) && (channel_s1 <= 3'(NC));

		// first mapped output carrying the requested channel
		for (int i = NO - 1; i >= 0; i--) begin
			if (used[i] && map_ch[i] == channel_s1) begin
				found = 1'b1;
				idx   = spmpwm_pkg::OUT_IDX_W'(i);
			end
		end

		if (op_s1 == spmpwm_pkg::OP_TICK) begin
			if (prescale_q < prescale_divisor_q) begin
				prescale_d = prescale_q + 16'd1;
			end else begin
				prescale_d = '0;
				unique case (counter_mode_q)
					spmpwm_pkg::MODE_DOWN: begin
						if (count_q == '0) begin
							count_d = reload_q;
							upd     = 1'b1;
						end else begin
							count_d = count_q - CW'(1);
						end
					end
					spmpwm_pkg::MODE_CENTER: begin
						if (!down_q) begin
							if (count_inc >= {1'b0, reload_q}) begin
								count_d = reload_q;
								down_d  = reload_q != '0;
								upd     = 1'b1;
							end else begin
								count_d = count_inc[CW-1:0];
							end
						end else if (count_q <= CW'(1)) begin
							count_d = '0;
							down_d  = 1'b0;
							upd     = 1'b1;
						end else begin
							count_d = count_q - CW'(1);
						end
					end
					default: begin
						// up mode; mode code 3 counts the same way
						if (count_q >= reload_q) begin
							count_d = '0;
							upd     = 1'b1;
						end else begin
							count_d = count_inc[CW-1:0];
						end
					end
				endcase
				if (upd && upd_en_q)
					levels_d = levels_d | (active_q & used);
				for (int c = 0; c < NC; c++)
					ch_match[c] = cmp_en_q[c] && (count_d == compare_q[c]);
				// compare match pulls low after the update raise, so low wins
				for (int i = 0; i < NO; i++) begin
					if (used[i] && map_ch[i] >= 3'd1 && map_ch[i] <= 3'(NC)
							&& map_ch[i] <= 3'(spmpwm_pkg::CC_CHANNELS)
							&& ch_match[CH_IDX_W_L'(map_ch[i] - 3'd1)])
						levels_d[i] = 1'b0;
				end
			end
			ev_d = upd;
		end else if (!(ch_ok && found)) begin
			status_d = spmpwm_pkg::STATUS_BAD_CHANNEL;
		end else begin
			cmp_en_d[ch_idx] = 1'b0;
			if (!wide_counter_q && period_s1 > spmpwm_pkg::NARROW_LIMIT) begin
				status_d = spmpwm_pkg::STATUS_UNSUPPORTED;
			end else if (period_s1 == '0) begin
				armed_d[ch_idx] = 1'b0;
				active_d[idx]   = 1'b0;
				levels_d[idx]   = 1'b0;
				if ((active_d & used) == '0)
					upd_en_d = 1'b0;
			end else if (counter_mode_q != spmpwm_pkg::MODE_UP
					&& counter_mode_q != spmpwm_pkg::MODE_DOWN
					&& counter_mode_q != spmpwm_pkg::MODE_CENTER) begin
				status_d = spmpwm_pkg::STATUS_UNSUPPORTED;
			end else begin
				unique case (counter_mode_q)
					spmpwm_pkg::MODE_UP: begin
						per_adj = period_s1 - 32'd1;
					end
					spmpwm_pkg::MODE_DOWN: begin
						// zero pulse stays zero
						pul_adj = (pulse_s1 != '0) ? pulse_s1 - 32'd1 : '0;
						per_adj = period_s1 - 32'd1;
					end
					default: begin
						pul_adj = pulse_s1 >> 1;
						per_adj = period_s1 >> 1;
					end
				endcase
				compare_d[ch_idx] = pul_adj[CW-1:0] & mask;
				reload_d          = per_adj[CW-1:0] & mask;
				if (!armed_q[ch_idx]) begin
					armed_d[ch_idx] = 1'b1;
					prescale_d      = '0;
					down_d          = 1'b0;
					count_d         = (counter_mode_q == spmpwm_pkg::MODE_DOWN) ? reload_d : '0;
					forced          = 1'b1;
				end
				active_d[idx] = pul_adj != '0;
				if (pul_adj == '0) begin
					levels_d[idx] = 1'b0;
					if ((active_d & used) == '0)
						upd_en_d = 1'b0;
				end else if (pul_adj > per_adj) begin
					levels_d[idx] = 1'b1;
					upd_en_d      = 1'b1;
				end else begin
					cmp_en_d[ch_idx] = 1'b1;
					upd_en_d         = 1'b1;
				end
				if (forced && upd_en_d)
					levels_d = levels_d | (active_d & used);
				ev_d = forced;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			down_q     <= 1'b0;
			prescale_q <= '0;
			reload_q   <= '0;
			for (int c = 0; c < NC; c++)
				compare_q[c] <= '0;
			active_q   <= '0;
			cmp_en_q   <= '0;
			armed_q    <= '0;
			upd_en_q   <= 1'b0;
			levels_q   <= spmpwm_pkg::LEVELS_RESET;
		end else if (advance) begin
			count_q    <= count_d;
			down_q     <= down_d;
			prescale_q <= prescale_d;
			reload_q   <= reload_d;
			compare_q  <= compare_d;
			active_q   <= active_d;
			cmp_en_q   <= cmp_en_d;
			armed_q    <= armed_d;
			upd_en_q   <= upd_en_d;
			levels_q   <= levels_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_q       <= status_d;
			pin_levels_q   <= levels_d & used;
			update_event_q <= ev_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign pin_levels   = pin_levels_q;
	assign update_event = update_event_q;

	// the input side only stalls behind a result that is not taken
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && out_valid_q && !out_ready))
		else $error("input stalled without a blocked result");

	// a rejected set never reports an update event
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q != spmpwm_pkg::STATUS_OK) |-> !update_event_q)
		else $error("update event on a rejected set");

	// compare enables are set only on armed channels
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmp_en_q & ~armed_q) == '0)
		else $error("compare enabled on an unarmed channel");

	// a held result stays put while the sink stalls
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> (out_valid_q && $stable(pin_levels_q)
			&& $stable(update_event_q)))
		else $error("result changed while stalled");

endmodule
